// File: design/crc32c_packet_deframer_assert.svh
// Assertion macros used by the deframer checker.
`ifndef CRC32C_PACKET_DEFRAMER_ASSERT_SVH
`define CRC32C_PACKET_DEFRAMER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CPD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/cpd_pkg.sv
`default_nettype none
package cpd_pkg;

   // packet layout, in bytes
   localparam int unsigned ID_BYTES     = 8;
   localparam int unsigned HDR_CRC_SPAN = 12;
   localparam int unsigned HDR_BYTES    = 16;
   localparam int unsigned TRL_BYTES    = 4;

   localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_GOOD    = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_HDR_CRC  = 2'd1;
   localparam logic [1:0] ERR_LENGTH   = 2'd2;
   localparam logic [1:0] ERR_DATA_CRC = 2'd3;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PAYLOAD,
      PH_TRAILER
   } phase_type;

   // one staged stream byte
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } byte_stage_type;

   // reflected CRC32C, one byte
   function automatic logic [31:0] crc32c_byte(input logic [31:0] crc,
                                               input logic [7:0]  data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// File: design/cpd_in_reg.sv
`default_nettype none
module cpd_in_reg (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [7:0]              req_stream_byte,
   input  wire logic                    take,
   output cpd_pkg::byte_stage_type      stage
);
   import cpd_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       accept;

   assign req_ready = !valid_ff || take;
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (accept) begin
         valid_in = 1'b1;
         data_in  = req_stream_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign stage.valid = valid_ff;
   assign stage.data  = data_ff;

endmodule
`default_nettype wire

// File: design/cpd_core.sv
`default_nettype none
module cpd_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cpd_pkg::byte_stage_type stage,
   output logic                         take,
   input  wire logic                    csr_wr_en,
   input  wire logic [31:0]             csr_wr_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [1:0]                   rsp_kind,
   output logic [7:0]                   rsp_payload_byte,
   output logic [63:0]                  rsp_packet_id,
   output logic [31:0]                  rsp_payload_len,
   output logic [1:0]                   rsp_error_code,
   output logic                         rsp_last_of_packet
);
   import cpd_pkg::*;

   // packet state
   phase_type   phase_ff, phase_in;
   logic        halted_ff, halted_in;
   logic [31:0] pos_ff, pos_in;
   logic [63:0] id_ff, id_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] hcrc_ff, hcrc_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] trl_ff, trl_in;
   logic [31:0] max_len_ff, max_len_in;

   // result register
   logic        res_valid_ff, res_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  pbyte_ff, pbyte_in;
   logic [63:0] rid_ff, rid_in;
   logic [31:0] rlen_ff, rlen_in;
   logic [1:0]  code_ff, code_in;
   logic        last_ff, last_in;

   logic [7:0]  b;
   logic [3:0]  hpos;
   logic [31:0] hcrc_full;
   logic [31:0] trl_full;
   logic [31:0] pos_inc;
   logic        res_load;

   assign take      = stage.valid && (!res_valid_ff || rsp_ready);
   assign b         = stage.data;
   assign hpos      = pos_ff[3:0];
   assign hcrc_full = {b, hcrc_ff[31:8]};
   assign trl_full  = {b, trl_ff[31:8]};
   assign pos_inc   = pos_ff + 32'd1;

   assign max_len_in = csr_wr_en ? csr_wr_data : max_len_ff;

   always_comb begin
      phase_in  = phase_ff;
      halted_in = halted_ff;
      pos_in    = pos_ff;
      id_in     = id_ff;
      len_in    = len_ff;
      hcrc_in   = hcrc_ff;
      crc_in    = crc_ff;
      trl_in    = trl_ff;
      res_load  = 1'b0;
      kind_in   = KIND_PAYLOAD;
      pbyte_in  = 8'd0;
      code_in   = ERR_NONE;
      last_in   = 1'b0;
      rid_in    = id_ff;
      rlen_in   = len_ff;

      if (take && !halted_ff) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (hpos < 4'(ID_BYTES)) begin
                  id_in = {id_ff[55:0], b};
               end else if (hpos < 4'(HDR_CRC_SPAN)) begin
                  len_in = {len_ff[23:0], b};
               end else begin
                  hcrc_in = hcrc_full;
               end
               if (hpos < 4'(HDR_CRC_SPAN)) begin
                  crc_in = crc32c_byte(crc_ff, b);
               end
               if (hpos == 4'(HDR_BYTES - 1)) begin
                  pos_in = 32'd0;
                  if (~crc_ff != hcrc_full) begin
                     halted_in = 1'b1;
                     res_load  = 1'b1;
                     kind_in   = KIND_ERROR;
                     code_in   = ERR_HDR_CRC;
                     last_in   = 1'b1;
                  end else if (len_ff > max_len_ff) begin
                     halted_in = 1'b1;
                     res_load  = 1'b1;
                     kind_in   = KIND_ERROR;
                     code_in   = ERR_LENGTH;
                     last_in   = 1'b1;
                  end else begin
                     crc_in   = CRC_INIT;
                     phase_in = (len_ff == 32'd0) ? PH_TRAILER : PH_PAYLOAD;
                  end
               end else begin
                  pos_in = pos_inc;
               end
            end
            PH_PAYLOAD: begin
               crc_in = crc32c_byte(crc_ff, b);
               if (pos_inc >= len_ff) begin
                  pos_in   = 32'd0;
                  phase_in = PH_TRAILER;
               end else begin
                  pos_in = pos_inc;
               end
               res_load = 1'b1;
               kind_in  = KIND_PAYLOAD;
               pbyte_in = b;
            end
            PH_TRAILER: begin
               trl_in = trl_full;
               if (pos_ff[1:0] == 2'(TRL_BYTES - 1)) begin
                  res_load = 1'b1;
                  last_in  = 1'b1;
                  if (((~crc_ff) ^ trl_full) == hcrc_ff) begin
                     kind_in  = KIND_GOOD;
                     // start over on a fresh header
                     phase_in = PH_HEADER;
                     pos_in   = 32'd0;
                     id_in    = 64'd0;
                     len_in   = 32'd0;
                     hcrc_in  = 32'd0;
                     crc_in   = CRC_INIT;
                     trl_in   = 32'd0;
                  end else begin
                     kind_in   = KIND_ERROR;
                     code_in   = ERR_DATA_CRC;
                     halted_in = 1'b1;
                  end
               end else begin
                  pos_in = pos_inc;
               end
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase
      end

      if (res_load) begin
         res_valid_in = 1'b1;
      end else if (rsp_ready) begin
         res_valid_in = 1'b0;
      end else begin
         res_valid_in = res_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         halted_ff    <= 1'b0;
         pos_ff       <= 32'd0;
         id_ff        <= 64'd0;
         len_ff       <= 32'd0;
         hcrc_ff      <= 32'd0;
         crc_ff       <= CRC_INIT;
         trl_ff       <= 32'd0;
         max_len_ff   <= 32'hFFFF_FFFF;
         res_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         halted_ff    <= halted_in;
         pos_ff       <= pos_in;
         id_ff        <= id_in;
         len_ff       <= len_in;
         hcrc_ff      <= hcrc_in;
         crc_ff       <= crc_in;
         trl_ff       <= trl_in;
         max_len_ff   <= max_len_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         kind_ff  <= kind_in;
         pbyte_ff <= pbyte_in;
         rid_ff   <= rid_in;
         rlen_ff  <= rlen_in;
         code_ff  <= code_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid          = res_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_payload_byte   = pbyte_ff;
   assign rsp_packet_id      = rid_ff;
   assign rsp_payload_len    = rlen_ff;
   assign rsp_error_code     = code_ff;
   assign rsp_last_of_packet = last_ff;

endmodule
`default_nettype wire

// File: design/crc32c_packet_deframer.sv
// CRC32C-checked, length-prefixed packet deframer.
// req_*: stream bytes, one per transfer (valid/ready). Each packet is a
//   16-byte header (64-bit ID and 32-bit length, both big-endian, then the
//   CRC32C of those 12 bytes, low byte first), the payload bytes, and a
//   4-byte trailer equal to CRC32C(payload) XOR the header CRC.
// rsp_*: at most one result per byte: each payload byte (kind 0), a good
//   verdict on the last trailer byte (kind 1), or an error verdict (kind 2)
//   with its code. Verdicts set rsp_last_of_packet.
// csr_*: max_payload_len, written with csr_wr_en; used by the next header.
// Path: a byte passes the input register, then the result register, before
//   its result shows on rsp_valid.
//   Throughput: one byte per cycle unless the receiver stalls; the per-byte
//   CRC update and the header/trailer compares sit in one stage.
// Reset (synchronous): back to header phase, limit = all ones, no result.
// Receiver stall: the pending result holds in the result register; one more
//   byte may wait in the input register, after which req_ready drops.
// After any error verdict the block keeps taking bytes but emits nothing
//   until reset.
`default_nettype none
module crc32c_packet_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_stream_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_payload_byte,
   output logic [63:0]      rsp_packet_id,
   output logic [31:0]      rsp_payload_len,
   output logic [1:0]       rsp_error_code,
   output logic             rsp_last_of_packet,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);
   import cpd_pkg::*;

   byte_stage_type stage;   // staged byte from the input register
   logic           take;    // core consumes the staged byte this cycle

   cpd_in_reg u_in_reg (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stream_byte (req_stream_byte),
      .take            (take),
      .stage           (stage)
   );

   // header parse, CRC checks and result register
   cpd_core u_core (
      .clock              (clock),
      .reset              (reset),
      .stage              (stage),
      .take               (take),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_packet_id      (rsp_packet_id),
      .rsp_payload_len    (rsp_payload_len),
      .rsp_error_code     (rsp_error_code),
      .rsp_last_of_packet (rsp_last_of_packet)
   );

endmodule
`default_nettype wire

// File: design/cpd_checker.sv
`default_nettype none
`include "crc32c_packet_deframer_assert.svh"
module cpd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_kind,
   input wire logic [7:0]  rsp_payload_byte,
   input wire logic [63:0] rsp_packet_id,
   input wire logic [31:0] rsp_payload_len,
   input wire logic [1:0]  rsp_error_code,
   input wire logic        rsp_last_of_packet
);
   import cpd_pkg::*;

   // stalled result holds
   `CPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_kind) && $stable(rsp_payload_byte) &&
      $stable(rsp_packet_id) && $stable(rsp_payload_len) &&
      $stable(rsp_error_code) && $stable(rsp_last_of_packet),
      "result changed while stalled")

   // payload bytes carry no verdict
   `CPD_ASSERT_NOW(a_payload_fields, clock, reset,
      rsp_valid && rsp_kind == KIND_PAYLOAD,
      !rsp_last_of_packet && rsp_error_code == ERR_NONE,
      "payload result with verdict fields")

   // verdicts end a packet, carry no byte, and code matches kind
   `CPD_ASSERT_NOW(a_verdict_fields, clock, reset,
      rsp_valid && rsp_kind != KIND_PAYLOAD,
      rsp_last_of_packet && rsp_payload_byte == 8'd0 &&
      ((rsp_kind == KIND_GOOD) == (rsp_error_code == ERR_NONE)),
      "malformed verdict result")

   // nothing follows an error verdict
   `CPD_ASSERT_NEXT(a_halt_after_error, clock, reset,
      rsp_valid && rsp_ready && rsp_kind == KIND_ERROR,
      !rsp_valid,
      "result after error verdict")

endmodule

bind crc32c_packet_deframer cpd_checker u_cpd_checker (.*);
`default_nettype wire
